>>> src/rtcseq_pkg.sv
`timescale 1ns / 1ps
// rtcseq_pkg: types, constants and small conversion functions for the
// three-wire rtc time sequencer. no dependencies.
package rtcseq_pkg;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_OPEN  = 4'd1,
        PH_ENAB  = 4'd2,
        PH_BLOW  = 4'd3,
        PH_BHIGH = 4'd4,
        PH_WEND  = 4'd5,
        PH_TR0   = 4'd6,
        PH_TR1   = 4'd7,
        PH_TR2   = 4'd8,
        PH_TR3   = 4'd9,
        PH_TR4   = 4'd10
    } rtc_phase_t;

    typedef enum logic {
        OP_SET_TIME  = 1'b0,
        OP_READ_TIME = 1'b1
    } rtc_op_t;

    localparam logic [7:0] ADDR_WP_WR   = 8'h8e;
    localparam logic [7:0] ADDR_HOUR_WR = 8'h84;
    localparam logic [7:0] ADDR_MIN_WR  = 8'h82;
    localparam logic [7:0] ADDR_SEC_WR  = 8'h80;
    localparam logic [7:0] ADDR_HOUR_RD = 8'h85;
    localparam logic [7:0] ADDR_MIN_RD  = 8'h83;
    localparam logic [7:0] ADDR_SEC_RD  = 8'h81;
    localparam logic [7:0] WP_SET_DATA  = 8'h80;

    localparam logic [2:0] LAST_FRAME_RD = 3'd2;
    localparam logic [2:0] LAST_FRAME_WR = 3'd4;

    typedef struct packed {
        rtc_phase_t  phase;
        logic [2:0]  frame_index;
        logic [4:0]  bit_count;
        logic [7:0]  shift_byte;
        logic        op_latched;
        logic [23:0] bcd_time;
        logic [23:0] read_time;
    } rtc_state_t;

    typedef struct packed {
        logic       clock_pin;
        logic       data_out;
        logic       data_drive;
        logic       enable_pin;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_hours;
        logic [7:0] read_minutes;
        logic [7:0] read_seconds;
    } rtc_result_t;

    // tens by multiply with 26/256, exact for values below 69
    function automatic logic [7:0] to_bcd(input logic [5:0] v);
        logic [10:0] prod;
        logic [2:0]  tens;
        logic [5:0]  units;
        prod  = 11'(v) * 11'd26;
        tens  = prod[10:8];
        units = 6'(v - 6'(6'(tens) * 6'd10));
        return {1'b0, tens, units[3:0]};
    endfunction

    // high nibble times ten plus low nibble, no masking
    function automatic logic [7:0] from_bcd(input logic [7:0] b);
        logic [8:0] sum;
        sum = 9'({b[7:4], 3'b000}) + 9'({b[7:4], 1'b0}) + 9'(b[3:0]);
        return sum[7:0];
    endfunction

    function automatic logic [1:0] mod3(input logic [2:0] v);
        logic [1:0] r;
        case (v)
            3'd0, 3'd3, 3'd6: r = 2'd0;
            3'd1, 3'd4, 3'd7: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] write_addr(input logic [2:0] fi);
        logic [7:0] a;
        case (fi)
            3'd1, 3'd6: a = ADDR_HOUR_WR;
            3'd2, 3'd7: a = ADDR_MIN_WR;
            3'd3:       a = ADDR_SEC_WR;
            default:    a = ADDR_WP_WR;
        endcase
        return a;
    endfunction

    function automatic logic [7:0] read_addr(input logic [2:0] fi);
        logic [7:0] a;
        case (mod3(fi))
            2'd0:    a = ADDR_HOUR_RD;
            2'd1:    a = ADDR_MIN_RD;
            default: a = ADDR_SEC_RD;
        endcase
        return a;
    endfunction

endpackage

>>> src/three_wire_rtc_time_sequencer_core.sv
`timescale 1ns / 1ps
// three_wire_rtc_time_sequencer_core: input register, tick logic and result
// register of the three-wire rtc sequencer. uses rtcseq_pkg, rtcseq_step.
//
//  channel  direction  handshake           payload
//  s_       in         s_valid / s_ready   start_req operation hours minutes
//                                          seconds data_pin
//  m_       out        m_valid / m_ready   pin levels, busy, done, read time
//
// one transfer per cycle sustained while m_ready is high; a tick passes the
// input register, then the result register, on its way to the output.
// the sequencer state advances when a tick moves from the input register into
// the result register, so a stalled result holds the state.
// aresetn is synchronous, active low; it empties both registers and returns
// the sequencer to idle with all time registers cleared.
module three_wire_rtc_time_sequencer_core
    import rtcseq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_start_req,
    input  logic       s_operation,
    input  logic [4:0] s_hours,
    input  logic [5:0] s_minutes,
    input  logic [5:0] s_seconds,
    input  logic       s_data_pin,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_clock_pin,
    output logic       m_data_out,
    output logic       m_data_drive,
    output logic       m_enable_pin,
    output logic       m_busy_res,
    output logic       m_done_res,
    output logic [7:0] m_read_hours,
    output logic [7:0] m_read_minutes,
    output logic [7:0] m_read_seconds
);

    logic        in_valid_reg;
    logic        start_req_reg;
    logic        operation_reg;
    logic [4:0]  hours_reg;
    logic [5:0]  minutes_reg;
    logic [5:0]  seconds_reg;
    logic        data_pin_reg;
    logic        m_valid_reg;
    rtc_result_t result_reg;
    rtc_result_t result_next;
    rtc_state_t  state_reg;
    rtc_state_t  state_next;
    logic        advance;
    logic        s_xfer;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign s_xfer  = s_valid && s_ready;

    rtcseq_step u_step (
        .cur_state  (state_reg),
        .start_req  (start_req_reg),
        .operation  (operation_reg),
        .hours      (hours_reg),
        .minutes    (minutes_reg),
        .seconds    (seconds_reg),
        .data_pin   (data_pin_reg),
        .next_state (state_next),
        .result     (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            start_req_reg <= s_start_req;
            operation_reg <= s_operation;
            hours_reg     <= s_hours;
            minutes_reg   <= s_minutes;
            seconds_reg   <= s_seconds;
            data_pin_reg  <= s_data_pin;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            state_reg   <= '{phase: PH_IDLE, default: '0};
        end else if (advance) begin
            m_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            result_reg <= result_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_clock_pin    = result_reg.clock_pin;
    assign m_data_out     = result_reg.data_out;
    assign m_data_drive   = result_reg.data_drive;
    assign m_enable_pin   = result_reg.enable_pin;
    assign m_busy_res     = result_reg.busy_res;
    assign m_done_res     = result_reg.done_res;
    assign m_read_hours   = result_reg.read_hours;
    assign m_read_minutes = result_reg.read_minutes;
    assign m_read_seconds = result_reg.read_seconds;

`ifndef NO_ASSERTIONS
    // a completing tick is always part of an operation
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_done_res |-> m_busy_res)
        else $error("done without busy");

    // released data line never shows a driven level
    a_dout_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_out |-> m_data_drive)
        else $error("data level without drive");

    // idle sequencer always restarts at the first frame
    a_idle_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase == PH_IDLE |-> state_reg.frame_index == 3'd0)
        else $error("idle with nonzero frame index");

    // state only moves when a tick is handed to the result register
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(advance && in_valid_reg) |=> $stable(state_reg))
        else $error("state changed without a tick");
`endif

endmodule

>>> src/rtcseq_step.sv
`timescale 1ns / 1ps
// rtcseq_step: one pin tick of the sequencer, next state and pin levels
// from the current state and one input transfer. uses rtcseq_pkg.
module rtcseq_step
    import rtcseq_pkg::*;
(
    input  rtc_state_t  cur_state,
    input  logic        start_req,
    input  logic        operation,
    input  logic [4:0]  hours,
    input  logic [5:0]  minutes,
    input  logic [5:0]  seconds,
    input  logic        data_pin,
    output rtc_state_t  next_state,
    output rtc_result_t result
);

    always_comb begin
        rtc_state_t st;
        logic       clk;
        logic       dout;
        logic       drv;
        logic       en;
        logic       busy;
        logic       done;
        logic       frame_end;
        logic       rd_bit;
        logic [2:0] last;

        st        = cur_state;
        clk       = 1'b0;
        dout      = 1'b0;
        drv       = 1'b0;
        en        = 1'b0;
        busy      = 1'b1;
        done      = 1'b0;
        frame_end = 1'b0;

        if (st.phase == PH_IDLE && start_req) begin
            st.op_latched  = operation;
            st.bcd_time    = {to_bcd({1'b0, hours}), to_bcd(minutes), to_bcd(seconds)};
            st.frame_index = 3'd0;
            st.bit_count   = 5'd0;
            st.phase       = PH_OPEN;
        end

        // data byte of a read frame is sampled, the address byte is driven
        rd_bit = st.op_latched && (st.bit_count[4] || st.bit_count[3]);

        case (st.phase)
            PH_OPEN: begin
                st.phase = PH_ENAB;
            end
            PH_ENAB: begin
                en           = 1'b1;
                st.bit_count = 5'd0;
                st.shift_byte = (rtc_op_t'(st.op_latched) == OP_READ_TIME)
                              ? read_addr(st.frame_index) : write_addr(st.frame_index);
                st.phase     = PH_BLOW;
            end
            PH_BLOW: begin
                en = 1'b1;
                if (rd_bit) begin
                    st.shift_byte = {data_pin, st.shift_byte[7:1]};
                end else begin
                    drv  = 1'b1;
                    dout = st.shift_byte[0];
                end
                st.phase = PH_BHIGH;
            end
            PH_BHIGH: begin
                en  = 1'b1;
                clk = 1'b1;
                if (!rd_bit) begin
                    drv           = 1'b1;
                    dout          = st.shift_byte[0];
                    st.shift_byte = {1'b0, st.shift_byte[7:1]};
                end
                if (st.bit_count == 5'd7) begin
                    if (rtc_op_t'(st.op_latched) == OP_READ_TIME) begin
                        st.shift_byte = 8'h00;
                    end else begin
                        case (st.frame_index)
                            3'd1:    st.shift_byte = st.bcd_time[23:16];
                            3'd2:    st.shift_byte = st.bcd_time[15:8];
                            3'd3:    st.shift_byte = st.bcd_time[7:0];
                            3'd4:    st.shift_byte = WP_SET_DATA;
                            default: st.shift_byte = 8'h00;
                        endcase
                    end
                    st.bit_count = 5'd8;
                    st.phase     = PH_BLOW;
                end else if (st.bit_count >= 5'd15) begin
                    st.bit_count = 5'd0;
                    if (rtc_op_t'(st.op_latched) == OP_READ_TIME) begin
                        case (mod3(st.frame_index))
                            2'd0:    st.read_time[23:16] = from_bcd(st.shift_byte);
                            2'd1:    st.read_time[15:8]  = from_bcd(st.shift_byte);
                            default: st.read_time[7:0]   = from_bcd(st.shift_byte);
                        endcase
                        st.phase = PH_TR0;
                    end else begin
                        st.phase = PH_WEND;
                    end
                end else begin
                    st.bit_count = st.bit_count + 5'd1;
                    st.phase     = PH_BLOW;
                end
            end
            PH_WEND: begin
                clk       = 1'b1;
                frame_end = 1'b1;
            end
            PH_TR0: begin
                clk      = 1'b1;
                st.phase = PH_TR1;
            end
            PH_TR1: begin
                st.phase = PH_TR2;
            end
            PH_TR2: begin
                clk      = 1'b1;
                st.phase = PH_TR3;
            end
            PH_TR3: begin
                clk      = 1'b1;
                drv      = 1'b1;
                st.phase = PH_TR4;
            end
            PH_TR4: begin
                clk       = 1'b1;
                drv       = 1'b1;
                dout      = 1'b1;
                frame_end = 1'b1;
            end
            default: begin
                busy     = 1'b0;
                st.phase = PH_IDLE;
            end
        endcase

        last = st.op_latched ? LAST_FRAME_RD : LAST_FRAME_WR;
        if (frame_end) begin
            if (st.frame_index >= last) begin
                done           = 1'b1;
                st.frame_index = 3'd0;
                st.phase       = PH_IDLE;
            end else begin
                st.frame_index = st.frame_index + 3'd1;
                st.phase       = PH_OPEN;
            end
        end

        next_state          = st;
        result.clock_pin    = clk;
        result.data_out     = dout;
        result.data_drive   = drv;
        result.enable_pin   = en;
        result.busy_res     = busy;
        result.done_res     = done;
        result.read_hours   = st.read_time[23:16];
        result.read_minutes = st.read_time[15:8];
        result.read_seconds = st.read_time[7:0];
    end

endmodule

>>> verif/rtc_sequencer_checker.sv
`timescale 1ns / 1ps
// rtc_sequencer_checker: watches both channels of the three-wire rtc sequencer,
// predicts the pin levels and read time of every tick and compares them.
// depends on rtcseq_pkg only.
module rtc_sequencer_checker
    import rtcseq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic       s_start_req,
    input  logic       s_operation,
    input  logic [4:0] s_hours,
    input  logic [5:0] s_minutes,
    input  logic [5:0] s_seconds,
    input  logic       s_data_pin,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic       m_clock_pin,
    input  logic       m_data_out,
    input  logic       m_data_drive,
    input  logic       m_enable_pin,
    input  logic       m_busy_res,
    input  logic       m_done_res,
    input  logic [7:0] m_read_hours,
    input  logic [7:0] m_read_minutes,
    input  logic [7:0] m_read_seconds,
    output int         mismatches,
    output int         pending
);

    localparam logic [7:0] WP_CLEAR_DATA = 8'h00;
    localparam int         MAX_REPORTS   = 100;

    rtc_phase_t  seq_phase;
    logic [2:0]  frame_idx;
    logic [4:0]  bit_idx;
    logic [7:0]  shifter;
    rtc_op_t     op_q;
    logic [23:0] bcd_q;
    logic [23:0] time_rd;
    rtc_result_t expected_ticks[$];
    int          result_num;

    function automatic logic [7:0] bcd_of(input int v);
        return 8'(((v / 10) << 4) | (v % 10));
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_REPORTS)
            $display("[%0t] result %0d: %s", $time, result_num, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    // one pin tick of the sequencer
    task automatic step_sequencer(input logic start, input rtc_op_t op,
                                  input logic [4:0] hr, input logic [5:0] mn,
                                  input logic [5:0] sc, input logic pin,
                                  output rtc_result_t r);
        logic       frame_end;
        logic       sampling;
        logic [2:0] last_frame;
        logic [7:0] decoded;
        r = '0;
        r.busy_res = 1'b1;
        frame_end = 1'b0;
        // the start tick is also the open tick of the first frame
        if (seq_phase == PH_IDLE && start) begin
            op_q = op;
            bcd_q = {bcd_of(hr), bcd_of(mn), bcd_of(sc)};
            frame_idx = '0;
            bit_idx = '0;
            seq_phase = PH_OPEN;
        end
        sampling = (op_q == OP_READ_TIME) && (bit_idx >= 5'd8);
        case (seq_phase)
            PH_OPEN: begin
                seq_phase = PH_ENAB;
            end
            PH_ENAB: begin
                r.enable_pin = 1'b1;
                bit_idx = '0;
                if (op_q == OP_READ_TIME) begin
                    case (frame_idx % 3)
                        0:       shifter = ADDR_HOUR_RD;
                        1:       shifter = ADDR_MIN_RD;
                        default: shifter = ADDR_SEC_RD;
                    endcase
                end else begin
                    case (frame_idx)
                        3'd1:    shifter = ADDR_HOUR_WR;
                        3'd2:    shifter = ADDR_MIN_WR;
                        3'd3:    shifter = ADDR_SEC_WR;
                        default: shifter = ADDR_WP_WR;
                    endcase
                end
                seq_phase = PH_BLOW;
            end
            PH_BLOW: begin
                r.enable_pin = 1'b1;
                if (sampling) begin
                    shifter = {pin, shifter[7:1]};
                end else begin
                    r.data_drive = 1'b1;
                    r.data_out = shifter[0];
                end
                seq_phase = PH_BHIGH;
            end
            PH_BHIGH: begin
                r.enable_pin = 1'b1;
                r.clock_pin = 1'b1;
                if (!sampling) begin
                    r.data_drive = 1'b1;
                    r.data_out = shifter[0];
                    shifter = shifter >> 1;
                end
                if (bit_idx == 5'd7) begin
                    // address sent, load the data byte
                    if (op_q == OP_READ_TIME) begin
                        shifter = '0;
                    end else begin
                        case (frame_idx)
                            3'd1:    shifter = bcd_q[23:16];
                            3'd2:    shifter = bcd_q[15:8];
                            3'd3:    shifter = bcd_q[7:0];
                            3'd4:    shifter = WP_SET_DATA;
                            default: shifter = WP_CLEAR_DATA;
                        endcase
                    end
                    bit_idx = 5'd8;
                    seq_phase = PH_BLOW;
                end else if (bit_idx >= 5'd15) begin
                    bit_idx = '0;
                    if (op_q == OP_READ_TIME) begin
                        // unmasked decode, 0xff gives 165
                        decoded = 8'(int'(shifter[7:4]) * 10 + int'(shifter[3:0]));
                        case (frame_idx % 3)
                            0:       time_rd[23:16] = decoded;
                            1:       time_rd[15:8] = decoded;
                            default: time_rd[7:0] = decoded;
                        endcase
                        seq_phase = PH_TR0;
                    end else begin
                        seq_phase = PH_WEND;
                    end
                end else begin
                    bit_idx = bit_idx + 5'd1;
                    seq_phase = PH_BLOW;
                end
            end
            PH_WEND: begin
                r.clock_pin = 1'b1;
                frame_end = 1'b1;
            end
            PH_TR0: begin
                r.clock_pin = 1'b1;
                seq_phase = PH_TR1;
            end
            PH_TR1: begin
                seq_phase = PH_TR2;
            end
            PH_TR2: begin
                r.clock_pin = 1'b1;
                seq_phase = PH_TR3;
            end
            PH_TR3: begin
                r.clock_pin = 1'b1;
                r.data_drive = 1'b1;
                seq_phase = PH_TR4;
            end
            PH_TR4: begin
                r.clock_pin = 1'b1;
                r.data_drive = 1'b1;
                r.data_out = 1'b1;
                frame_end = 1'b1;
            end
            default: begin
                r.busy_res = 1'b0;
            end
        endcase
        if (frame_end) begin
            last_frame = (op_q == OP_READ_TIME) ? LAST_FRAME_RD : LAST_FRAME_WR;
            if (frame_idx >= last_frame) begin
                r.done_res = 1'b1;
                frame_idx = '0;
                seq_phase = PH_IDLE;
            end else begin
                frame_idx = frame_idx + 3'd1;
                seq_phase = PH_OPEN;
            end
        end
        r.read_hours = time_rd[23:16];
        r.read_minutes = time_rd[15:8];
        r.read_seconds = time_rd[7:0];
    endtask

    always @(posedge aclk) begin : monitor
        rtc_result_t want;
        if (!aresetn) begin
            seq_phase = PH_IDLE;
            frame_idx = '0;
            bit_idx = '0;
            shifter = '0;
            op_q = OP_SET_TIME;
            bcd_q = '0;
            time_rd = '0;
            expected_ticks.delete();
            mismatches = 0;
            result_num = 0;
        end else begin
            // a tick accepted now cannot come out at the same edge, so pop first
            if (m_valid && m_ready) begin
                if (expected_ticks.size() == 0) begin
                    report_mismatch("result transfer with no tick outstanding");
                end else begin
                    want = expected_ticks.pop_front();
                    check_field("clock_pin", m_clock_pin, want.clock_pin);
                    check_field("data_out", m_data_out, want.data_out);
                    check_field("data_drive", m_data_drive, want.data_drive);
                    check_field("enable_pin", m_enable_pin, want.enable_pin);
                    check_field("busy_res", m_busy_res, want.busy_res);
                    check_field("done_res", m_done_res, want.done_res);
                    check_field("read_hours", m_read_hours, want.read_hours);
                    check_field("read_minutes", m_read_minutes, want.read_minutes);
                    check_field("read_seconds", m_read_seconds, want.read_seconds);
                end
                result_num++;
            end
            if (s_valid && s_ready) begin
                step_sequencer(s_start_req, rtc_op_t'(s_operation), s_hours, s_minutes,
                               s_seconds, s_data_pin, want);
                expected_ticks.push_back(want);
            end
        end
        pending <= expected_ticks.size();
    end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// testbench: clock, reset and tick stimulus for three_wire_rtc_time_sequencer_core,
// with random stalls on both channels. uses rtcseq_pkg and rtc_sequencer_checker.
module testbench
    import rtcseq_pkg::*;
();

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 10;
    localparam int SET_TICKS       = 175;   // five frames of 35 ticks
    localparam int READ_TICKS      = 117;   // three frames of 39 ticks
    localparam int RANDOM_TICKS    = 560;
    localparam int GAP_MAX         = 18;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int DRAIN_CYCLES    = 8;
    localparam int WATCHDOG_CYCLES = 2000;

    typedef struct packed {
        logic       start_req;
        rtc_op_t    operation;
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic       data_pin;
    } rtc_tick_t;

    typedef enum {PINS_RANDOM, PINS_HIGH, PINS_LOW} pin_mode_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_start_req = 1'b0;
    logic       s_operation = 1'b0;
    logic [4:0] s_hours = '0;
    logic [5:0] s_minutes = '0;
    logic [5:0] s_seconds = '0;
    logic       s_data_pin = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_clock_pin;
    logic       m_data_out;
    logic       m_data_drive;
    logic       m_enable_pin;
    logic       m_busy_res;
    logic       m_done_res;
    logic [7:0] m_read_hours;
    logic [7:0] m_read_minutes;
    logic [7:0] m_read_seconds;

    int mismatches;
    int pending;
    int s_idle_pct = 0;
    int m_idle_pct = 0;
    bit hold_off_req = 1'b0;

    always #CLK_HALF aclk = ~aclk;

    three_wire_rtc_time_sequencer_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_start_req    (s_start_req),
        .s_operation    (s_operation),
        .s_hours        (s_hours),
        .s_minutes      (s_minutes),
        .s_seconds      (s_seconds),
        .s_data_pin     (s_data_pin),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_clock_pin    (m_clock_pin),
        .m_data_out     (m_data_out),
        .m_data_drive   (m_data_drive),
        .m_enable_pin   (m_enable_pin),
        .m_busy_res     (m_busy_res),
        .m_done_res     (m_done_res),
        .m_read_hours   (m_read_hours),
        .m_read_minutes (m_read_minutes),
        .m_read_seconds (m_read_seconds)
    );

    rtc_sequencer_checker tick_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_start_req    (s_start_req),
        .s_operation    (s_operation),
        .s_hours        (s_hours),
        .s_minutes      (s_minutes),
        .s_seconds      (s_seconds),
        .s_data_pin     (s_data_pin),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_clock_pin    (m_clock_pin),
        .m_data_out     (m_data_out),
        .m_data_drive   (m_data_drive),
        .m_enable_pin   (m_enable_pin),
        .m_busy_res     (m_busy_res),
        .m_done_res     (m_done_res),
        .m_read_hours   (m_read_hours),
        .m_read_minutes (m_read_minutes),
        .m_read_seconds (m_read_seconds),
        .mismatches     (mismatches),
        .pending        (pending)
    );

    function automatic rtc_tick_t random_tick();
        rtc_tick_t tk;
        tk.start_req = 1'($urandom_range(1));
        tk.operation = rtc_op_t'($urandom_range(1));
        tk.hours = 5'($urandom_range(31));
        tk.minutes = 6'($urandom_range(63));
        tk.seconds = 6'($urandom_range(63));
        tk.data_pin = 1'($urandom_range(1));
        return tk;
    endfunction

    // one transfer on the input channel, with an optional gap ahead of it
    task automatic send_tick(input rtc_tick_t tk);
        if (int'($urandom_range(99)) < s_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, GAP_MAX)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_start_req <= tk.start_req;
        s_operation <= tk.operation;
        s_hours <= tk.hours;
        s_minutes <= tk.minutes;
        s_seconds <= tk.seconds;
        s_data_pin <= tk.data_pin;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_noise(input int n);
        rtc_tick_t tk;
        repeat (n) begin
            tk = random_tick();
            tk.start_req = 1'b0;
            send_tick(tk);
        end
    endtask

    // start tick plus the ticks of one operation; stray starts land while busy
    task automatic run_operation(input rtc_op_t op, input logic [4:0] hr,
                                 input logic [5:0] mn, input logic [5:0] sc,
                                 input pin_mode_t pins, input int stray_pct,
                                 input int len);
        rtc_tick_t tk;
        int        i;
        for (i = 0; i < len; i++) begin
            tk = random_tick();
            tk.start_req = (i == 0) || (int'($urandom_range(99)) < stray_pct);
            if (i == 0) begin
                tk.operation = op;
                tk.hours = hr;
                tk.minutes = mn;
                tk.seconds = sc;
            end
            case (pins)
                PINS_HIGH: tk.data_pin = 1'b1;
                PINS_LOW:  tk.data_pin = 1'b0;
                default:   ;
            endcase
            send_tick(tk);
        end
    endtask

    initial begin : result_sink
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                // long hold so the block fills up and stalls its input
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end else if (int'($urandom_range(99)) < m_idle_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, GAP_MAX)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    initial begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < WATCHDOG_CYCLES) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_CYCLES);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        int        op_ticks;
        int        len;
        int        sel;
        bit        pressure_done;
        rtc_op_t   op;
        pin_mode_t pins;
        op_ticks = 0;
        pressure_done = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes, out of range time, decode extremes, start while busy
        s_idle_pct = 10;
        m_idle_pct = 10;
        send_noise(2);
        run_operation(OP_SET_TIME, 5'd31, 6'd63, 6'd63, PINS_RANDOM, 100, SET_TICKS);
        run_operation(OP_READ_TIME, 5'd0, 6'd0, 6'd0, PINS_HIGH, 0, READ_TICKS);
        run_operation(OP_READ_TIME, 5'd7, 6'd42, 6'd9, PINS_LOW, 100, READ_TICKS);
        send_noise(3);

        // random: mostly complete operations, some noise and cut-short ones
        while (op_ticks < RANDOM_TICKS) begin
            if (op_ticks >= RANDOM_TICKS * 85 / 100) begin
                s_idle_pct = 0;
                m_idle_pct = 0;
            end else if (op_ticks >= RANDOM_TICKS * 55 / 100) begin
                s_idle_pct = 5;
                m_idle_pct = 30;
            end else if (op_ticks >= RANDOM_TICKS * 45 / 100) begin
                s_idle_pct = 0;
                m_idle_pct = 0;
            end else begin
                s_idle_pct = 12;
                m_idle_pct = 12;
            end
            if (!pressure_done && op_ticks >= RANDOM_TICKS / 3) begin
                hold_off_req = 1'b1;
                pressure_done = 1'b1;
            end
            sel = $urandom_range(99);
            if (sel < 12) begin
                send_noise($urandom_range(1, 4));
            end else begin
                op = rtc_op_t'($urandom_range(1));
                len = (op == OP_READ_TIME) ? READ_TICKS : SET_TICKS;
                // cut short so the next start arrives mid operation
                if ($urandom_range(99) < 8)
                    len = $urandom_range(1, len - 1);
                case ($urandom_range(9))
                    0:       pins = PINS_HIGH;
                    1:       pins = PINS_LOW;
                    default: pins = PINS_RANDOM;
                endcase
                run_operation(op, 5'($urandom_range(31)), 6'($urandom_range(63)),
                              6'($urandom_range(63)), pins,
                              ($urandom_range(99) < 20) ? 3 : 0, len);
                op_ticks += len;
            end
        end
        s_valid <= 1'b0;

        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
